// ----- hw/rtl/vfld_pkg.sv -----
package vfld_pkg;

  // Field widths
  localparam int unsigned WordW   = 32;
  localparam int unsigned SecW    = 30;
  localparam int unsigned EpochW  = 6;
  localparam int unsigned DfW     = 24;
  localparam int unsigned AbsW    = 32;
  localparam int unsigned CountW  = 48;
  localparam int unsigned StatusW = 3;

  // Stream widths
  localparam int unsigned InW       = 2 * WordW;
  localparam int unsigned OutFieldW = StatusW + 3 * CountW + AbsW + DfW;
  localparam int unsigned OutW      = ((OutFieldW + 7) / 8) * 8;

  // Header bit positions
  localparam int unsigned EpochLsb = 24;

  // Calendar
  localparam int unsigned EpochN    = 1 << EpochW;
  localparam int unsigned BaseYear  = 2000;
  localparam int unsigned SecPerDay = 86400;

  // Configuration
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = DfW;
  localparam logic            HDR_LE_RESET = 1'b1;
  localparam logic [DfW-1:0]  DF_MAX_RESET = 24'd31249;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HDR_LE = 1'b0,
    CFG_DF_MAX = 1'b1
  } cfg_reg_t;

  typedef enum logic [StatusW-1:0] {
    ST_FIRST     = 3'd0,
    ST_IN_SEQ    = 3'd1,
    ST_LOST      = 3'd2,
    ST_NON_MONO  = 3'd3,
    ST_BACKWARDS = 3'd4
  } frame_status_t;

  // Decoded frame time
  typedef struct packed {
    logic [AbsW-1:0] abs_sec;
    logic [DfW-1:0]  df;
  } frame_time_t;

  // Per-frame sequence check result
  typedef struct packed {
    frame_status_t     status;
    logic [CountW-1:0] lost;
    frame_time_t       ftime;
  } frame_loss_t;

  typedef logic [AbsW-1:0] epoch_tab_t [EpochN];

  // Seconds from the base date to the start of each half-year epoch.
  // Epoch years run 2000..2031, where every fourth year is leap (2000 is
  // leap by the 400-year rule), so the low two year bits decide.
  function automatic epoch_tab_t build_epoch_tab();
    epoch_tab_t  tab;
    int unsigned days;
    int unsigned year;
    logic        leap;
    days = 0;
    for (int e = 0; e < EpochN; e++) begin
      year = BaseYear + (int'(e) >> 1);
      leap = (year[1:0] == 2'd0);
      if (e % 2 == 1) begin
        tab[e] = AbsW'((days + (leap ? 182 : 181)) * SecPerDay);
        days   = days + (leap ? 366 : 365);
      end else begin
        tab[e] = AbsW'(days * SecPerDay);
      end
    end
    return tab;
  endfunction

  localparam epoch_tab_t EPOCH_START = build_epoch_tab();

endpackage

// ----- hw/rtl/vfld_decode.sv -----
module vfld_decode (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hdr_le,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [vfld_pkg::WordW-1:0]  in_word0,
  input  logic [vfld_pkg::WordW-1:0]  in_word1,
  output logic                        out_valid,
  input  logic                        out_ready,
  output vfld_pkg::frame_time_t       out_time
);
  import vfld_pkg::*;

  logic [WordW-1:0]  w0;
  logic [WordW-1:0]  w1;
  logic              s1_valid_r;
  logic [SecW-1:0]   secs_r;
  logic [EpochW-1:0] epoch_r;
  logic [DfW-1:0]    df_r;
  logic              s1_ready;
  logic              s2_ready;
  logic              s2_valid_r;
  frame_time_t       time_r;
  frame_time_t       time_nxt;

  function automatic logic [WordW-1:0] swap_bytes(input logic [WordW-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // Put header words in little-endian order
  assign w0 = hdr_le ? in_word0 : swap_bytes(in_word0);
  assign w1 = hdr_le ? in_word1 : swap_bytes(in_word1);

  assign s2_ready = !s2_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: capture the header fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      secs_r  <= w0[SecW-1:0];
      epoch_r <= w1[EpochLsb +: EpochW];
      df_r    <= w1[DfW-1:0];
    end
  end

  // Absolute seconds: epoch start plus seconds into the epoch
  always_comb begin
    time_nxt.abs_sec = EPOCH_START[epoch_r] + AbsW'(secs_r);
    time_nxt.df      = df_r;
  end

  // Stage 2: hold the decoded time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_ready && s1_valid_r) begin
      time_r <= time_nxt;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_time  = time_r;

endmodule

// ----- hw/rtl/vfld_seq.sv -----
module vfld_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [vfld_pkg::DfW-1:0]  df_max,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  vfld_pkg::frame_time_t     in_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output vfld_pkg::frame_loss_t     out_loss
);
  import vfld_pkg::*;

  localparam int unsigned MulW = AbsW + DfW + 1;
  localparam int unsigned SumW = MulW + 1;

  logic              seen_r;
  logic [AbsW-1:0]   last_sec_r;
  logic [DfW-1:0]    last_df_r;
  logic              valid_r;
  frame_loss_t       loss_r;
  frame_loss_t       loss_nxt;
  logic              load;

  logic [DfW:0]      next_df;
  logic [DfW-1:0]    gap;
  logic [DfW-1:0]    tail;
  logic [AbsW-1:0]   skipped;
  logic [DfW:0]      per_sec;
  logic [MulW-1:0]   prod;
  logic [SumW-1:0]   span;
  logic [CountW-1:0] span_sat;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_ready && in_valid;

  // Same-second gap and cross-second span
  assign next_df  = {1'b0, last_df_r} + (DfW+1)'(1);
  assign gap      = in_time.df - last_df_r - DfW'(1);
  assign tail     = (last_df_r <= df_max) ? (df_max - last_df_r) : '0;
  assign skipped  = in_time.abs_sec - last_sec_r - AbsW'(1);
  assign per_sec  = {1'b0, df_max} + (DfW+1)'(1);
  assign prod     = MulW'(skipped) * MulW'(per_sec);
  assign span     = SumW'(prod) + SumW'(tail) + SumW'(in_time.df);
  assign span_sat = (|span[SumW-1:CountW]) ? '1 : span[CountW-1:0];

  // Classify the frame against the previous one
  always_comb begin
    loss_nxt.ftime  = in_time;
    loss_nxt.lost   = '0;
    loss_nxt.status = ST_FIRST;
    if (!seen_r) begin
      loss_nxt.status = ST_FIRST;
    end else if (in_time.abs_sec == last_sec_r) begin
      if ({1'b0, in_time.df} > next_df) begin
        loss_nxt.lost   = CountW'(gap);
        loss_nxt.status = ST_LOST;
      end else if (in_time.df <= last_df_r) begin
        loss_nxt.status = ST_NON_MONO;
      end else begin
        loss_nxt.status = ST_IN_SEQ;
      end
    end else if (in_time.abs_sec > last_sec_r) begin
      loss_nxt.lost   = span_sat;
      loss_nxt.status = (|span) ? ST_LOST : ST_IN_SEQ;
    end else begin
      loss_nxt.status = ST_BACKWARDS;
    end
  end

  // Advance the comparison state and hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      seen_r     <= 1'b0;
      last_sec_r <= '0;
      last_df_r  <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        seen_r     <= 1'b1;
        last_sec_r <= in_time.abs_sec;
        last_df_r  <= in_time.df;
      end
    end
    if (load) begin
      loss_r <= loss_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_loss  = loss_r;

endmodule

// ----- hw/rtl/vfld_accum.sv -----
module vfld_accum (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  vfld_pkg::frame_loss_t        in_loss,
  output logic                         out_valid,
  input  logic                         out_ready,
  output vfld_pkg::frame_loss_t        out_loss,
  output logic [vfld_pkg::CountW-1:0]  lost_total,
  output logic [vfld_pkg::CountW-1:0]  frames_total
);
  import vfld_pkg::*;

  logic              valid_r;
  frame_loss_t       loss_r;
  logic [CountW-1:0] lost_total_r;
  logic [CountW-1:0] frames_total_r;
  logic [CountW:0]   lost_add;
  logic [CountW:0]   frames_add;
  logic [CountW-1:0] lost_total_nxt;
  logic [CountW-1:0] frames_total_nxt;
  logic              load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_ready && in_valid;

  // Saturating running totals
  assign lost_add         = {1'b0, lost_total_r} + {1'b0, in_loss.lost};
  assign frames_add       = {1'b0, frames_total_r} + (CountW+1)'(1);
  assign lost_total_nxt   = lost_add[CountW] ? '1 : lost_add[CountW-1:0];
  assign frames_total_nxt = frames_add[CountW] ? '1 : frames_add[CountW-1:0];

  // Output register; the totals double as the accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r        <= 1'b0;
      lost_total_r   <= '0;
      frames_total_r <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        lost_total_r   <= lost_total_nxt;
        frames_total_r <= frames_total_nxt;
      end
    end
    if (load) begin
      loss_r <= in_loss;
    end
  end

  assign out_valid    = valid_r;
  assign out_loss     = loss_r;
  assign lost_total   = lost_total_r;
  assign frames_total = frames_total_r;

endmodule

// ----- hw/rtl/vdif_frame_loss_detector.sv -----
// Channel | Dir | Handshake             | Payload
// --------+-----+-----------------------+----------------------------------------
// in_     | in  | in_tvalid/in_tready   | tdata: header_word0, header_word1
// out_    | out | out_tvalid/out_tready | tdata: status, lost_now, seconds, df, ...
// cfg_    | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (register write)
//
// One item per cycle sustained while out_tready stays high; each item passes
// four register stages (header capture, epoch add, sequence check with the
// skipped-seconds multiply, running totals) before its result is presented.
// Each stage holds its item while the next one is full and stalled, so a
// waiting result does not block intake until the stages behind it fill.
// Synchronous active-low reset clears valids, comparison state and totals;
// configuration returns to little-endian headers and df_max 31249.
module vdif_frame_loss_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [31:0] header_word0, [63:32] header_word1
  input  logic [vfld_pkg::InW-1:0]      in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] frame_status, [50:3] lost_now, [82:51] absolute_seconds,
  // [106:83] frame_number, [154:107] lost_total, [202:155] frames_total,
  // [207:203] zero
  output logic [vfld_pkg::OutW-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vfld_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vfld_pkg::CfgDataW-1:0] cfg_data
);
  import vfld_pkg::*;

  logic              hdr_le_r;
  logic [DfW-1:0]    df_max_r;
  logic              dec_valid;
  logic              dec_ready;
  frame_time_t       dec_time;
  logic              seq_valid;
  logic              seq_ready;
  frame_loss_t       seq_loss;
  frame_loss_t       res_loss;
  logic [CountW-1:0] lost_total;
  logic [CountW-1:0] frames_total;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_le_r <= HDR_LE_RESET;
      df_max_r <= DF_MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HDR_LE: hdr_le_r <= cfg_data[0];
        CFG_DF_MAX: df_max_r <= cfg_data[DfW-1:0];
        default: ;
      endcase
    end
  end

  vfld_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr_le    (hdr_le_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word0  (in_tdata[WordW-1:0]),
    .in_word1  (in_tdata[InW-1:WordW]),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_time  (dec_time)
  );

  vfld_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .df_max    (df_max_r),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_time   (dec_time),
    .out_valid (seq_valid),
    .out_ready (seq_ready),
    .out_loss  (seq_loss)
  );

  vfld_accum u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (seq_valid),
    .in_ready     (seq_ready),
    .in_loss      (seq_loss),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_loss     (res_loss),
    .lost_total   (lost_total),
    .frames_total (frames_total)
  );

  // Pack the result item, first field lowest
  assign out_tdata = {
    (OutW - OutFieldW)'(0),
    frames_total,
    lost_total,
    res_loss.ftime.df,
    res_loss.ftime.abs_sec,
    res_loss.lost,
    res_loss.status
  };

endmodule
